/* src/bo_pkg.sv */
package bo_pkg;

   // defaults for the top level parameters
   localparam int MaxNeighboursDef = 255;
   localparam int CoordBitsDef     = 24;
   localparam int CordicStepsDef   = 16;

   // datapath widths
   localparam int CW    = 34;   // CORDIC x/y/z datapath
   localparam int SUM_W = 25;   // running sums
   localparam int Q15_W = 17;   // rotated cos/sin, Q1.15 with room for +32768
   localparam int SQ_W  = 48;   // re^2 + im^2
   localparam int MAG_W = 24;   // floor(sqrt(...))
   localparam int CNT_W = 8;

   localparam logic [CW-1:0] RotStart = CW'(64'h26DD3B6A);
   localparam logic [31:0]   CutoffReset = 32'd16777216;
   localparam logic [15:0]   OrderMax = 16'd32768;

   // arctan(2^-i) as 32-bit binary angle
   function automatic logic [31:0] atan_lut(input logic [4:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;  5'd31: r = 32'h00000000;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   typedef enum logic [1:0] {
      CRD_IDLE, CRD_NORM, CRD_ITER, CRD_DONE
   } crd_state_type;

   typedef struct packed {
      logic start;
      logic rotate;
   } crd_ctl_type;

   typedef enum logic [3:0] {
      TS_IDLE, TS_SQX, TS_SQY, TS_CHK, TS_VEC, TS_RSTART, TS_ROT, TS_CLOSE,
      TS_FVEC, TS_MSQR, TS_MSQI, TS_SQRT, TS_DIVI, TS_DIV, TS_NEXT, TS_OUT
   } seq_state_type;

endpackage

/* src/bo_if.sv */
interface bo_req_if #(parameter int COORD_BITS = bo_pkg::CoordBitsDef);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] dx;
   logic signed [COORD_BITS-1:0] dy;
   logic                         is_self;
   logic                         last_candidate;
   modport source(output valid, dx, dy, is_self, last_candidate, input ready);
   modport sink(input valid, dx, dy, is_self, last_candidate, output ready);
endinterface

interface bo_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        order5;
   logic [15:0]        order6;
   logic [15:0]        order7;
   logic signed [15:0] order6_angle;
   logic [7:0]         neighbour_count;
   modport source(output valid, order5, order6, order7, order6_angle, neighbour_count,
                  input ready);
   modport sink(input valid, order5, order6, order7, order6_angle, neighbour_count,
                output ready);
endinterface

/* src/bo_cordic.sv */
module bo_cordic #(
   parameter int CORDIC_STEPS = bo_pkg::CordicStepsDef
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bo_pkg::crd_ctl_type             ctl,
   input  logic signed [bo_pkg::CW-1:0]    x_in,
   input  logic signed [bo_pkg::CW-1:0]    y_in,
   input  logic [31:0]                     phi_in,
   output logic                            done,
   output logic [31:0]                     ang_out,
   output logic signed [bo_pkg::Q15_W-1:0] cos_out,
   output logic signed [bo_pkg::Q15_W-1:0] sin_out
);
   import bo_pkg::*;

   localparam int IW = $clog2(CORDIC_STEPS);
   localparam logic [CW-1:0] NormHi = CW'(64'd1 << 29);
   localparam logic [CW-1:0] NormLo = CW'(64'd1 << 21);

   crd_state_type         state_ff, state_in;
   logic signed [CW-1:0]  x_ff, x_in_n, y_ff, y_in_n, z_ff, z_in;
   logic [IW-1:0]         i_ff, i_in;
   logic                  rot_ff, rot_in, neg_ff, neg_in;

   // round to Q1.15 and clamp to +-32768
   function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [CW-1:0] v);
      logic signed [CW:0]    t;
      logic signed [CW-15:0] s;
      t = $signed({v[CW-1], v}) + $signed((CW+1)'(64'd16384));
      s = $signed(t[CW:15]);
      if (s > $signed((CW-14)'(64'd32768)))
         return Q15_W'(64'd32768);
      else if (s < -$signed((CW-14)'(64'd32768)))
         return -$signed(Q15_W'(64'd32768));
      else
         return Q15_W'(s);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CRD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff   <= x_in_n;
      y_ff   <= y_in_n;
      z_ff   <= z_in;
      i_ff   <= i_in;
      rot_ff <= rot_in;
      neg_ff <= neg_in;
   end

   // sequencer and shared add/shift unit
   always_comb begin
      logic [31:0]          ph;
      logic [CW-1:0]        ax, ay, m;
      logic signed [CW-1:0] xs, ys, at;
      logic                 ccw;
      state_in = state_ff;
      x_in_n   = x_ff;
      y_in_n   = y_ff;
      z_in     = z_ff;
      i_in     = i_ff;
      rot_in   = rot_ff;
      neg_in   = neg_ff;
      done     = 1'b0;
      ph       = '0;
      ax       = x_ff[CW-1] ? CW'(-x_ff) : CW'(x_ff);
      ay       = y_ff[CW-1] ? CW'(-y_ff) : CW'(y_ff);
      m        = (ax > ay) ? ax : ay;
      xs       = x_ff >>> i_ff;
      ys       = y_ff >>> i_ff;
      at       = $signed(CW'(atan_lut(5'(i_ff))));
      ccw      = rot_ff ? !z_ff[CW-1] : y_ff[CW-1];
      unique case (state_ff)
         CRD_IDLE: begin
            if (ctl.start) begin
               rot_in = ctl.rotate;
               i_in   = '0;
               if (ctl.rotate) begin
                  // fold into [-pi/2, pi/2)
                  neg_in = (phi_in[31:30] == 2'd1) || (phi_in[31:30] == 2'd2);
                  ph     = neg_in ? phi_in - 32'h80000000 : phi_in;
                  x_in_n = $signed(RotStart);
                  y_in_n = '0;
                  z_in   = $signed({{(CW-32){ph[31]}}, ph});
                  state_in = CRD_ITER;
               end else begin
                  neg_in = 1'b0;
                  if (x_in == '0 && y_in == '0) begin
                     z_in     = '0;
                     state_in = CRD_DONE;
                  end else if (x_in[CW-1]) begin
                     x_in_n   = -x_in;
                     y_in_n   = -y_in;
                     z_in     = $signed(CW'(64'h80000000));
                     state_in = CRD_NORM;
                  end else begin
                     x_in_n   = x_in;
                     y_in_n   = y_in;
                     z_in     = '0;
                     state_in = CRD_NORM;
                  end
               end
            end
         end
         CRD_NORM: begin
            // scale up until the larger magnitude reaches 2^29
            if (m >= NormHi) begin
               state_in = CRD_ITER;
            end else if (m < NormLo) begin
               x_in_n = x_ff <<< 8;
               y_in_n = y_ff <<< 8;
            end else begin
               x_in_n = x_ff <<< 1;
               y_in_n = y_ff <<< 1;
            end
         end
         CRD_ITER: begin
            if (ccw) begin
               x_in_n = x_ff - ys;
               y_in_n = y_ff + xs;
               z_in   = z_ff - at;
            end else begin
               x_in_n = x_ff + ys;
               y_in_n = y_ff - xs;
               z_in   = z_ff + at;
            end
            if (i_ff == IW'(CORDIC_STEPS - 1))
               state_in = CRD_DONE;
            else
               i_in = i_ff + IW'(1);
         end
         CRD_DONE: begin
            done     = 1'b1;
            state_in = CRD_IDLE;
         end
         default: state_in = CRD_IDLE;
      endcase
   end

   assign ang_out = z_ff[31:0];
   assign cos_out = to_q15(neg_ff ? -x_ff : x_ff);
   assign sin_out = to_q15(neg_ff ? -y_ff : y_ff);

endmodule

/* src/bond_orientational_order.sv */
// Candidate word: a neighbour takes up to 10 normalize shifts, then one vectoring
// and three rotations of CORDIC_STEPS iterations each on the shared CORDIC unit;
// a word that is no neighbour does not use the CORDIC unit. A closing word adds a
// vectoring pass and per order a 24-step square root and a 25-step divide, one bit
// a cycle. One word at a time; ready only while idle.
// Reset (synchronous) clears sums and count and sets the squared cutoff to 16777216.
module bond_orientational_order #(
   parameter int MAX_NEIGHBOURS = bo_pkg::MaxNeighboursDef,
   parameter int COORD_BITS     = bo_pkg::CoordBitsDef,
   parameter int CORDIC_STEPS   = bo_pkg::CordicStepsDef
) (
   input  logic        clock,
   input  logic        reset,
   bo_req_if.sink      req_ch,
   bo_rsp_if.source    rsp_ch,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import bo_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int CountCap = (MAX_NEIGHBOURS > 255) ? 255 : MAX_NEIGHBOURS;

   seq_state_type              state_ff, state_in;
   logic [31:0]                cutoff_ff;
   logic signed [CB-1:0]       dx_ff, dx_in, dy_ff, dy_in;
   logic                       self_ff, self_in, last_ff, last_in;
   logic [2*CB:0]              r2_ff, r2_in;
   logic [31:0]                theta_ff, theta_in;
   logic [1:0]                 k_ff, k_in;
   logic signed [SUM_W-1:0]    sre_ff [3], sre_in [3], sim_ff [3], sim_in [3];
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [SQ_W-1:0]            acc_ff, acc_in, root_ff, root_in, bit_ff, bit_in;
   logic [SUM_W-1:0]           num_ff, num_in;
   logic [CNT_W:0]             rem_ff, rem_in;
   logic [4:0]                 step_ff, step_in;
   logic [15:0]                ord_ff [3], ord_in [3];
   logic [15:0]                ang_ff, ang_in;

   crd_ctl_type                crd_ctl;
   logic signed [CW-1:0]       crd_x, crd_y;
   logic [31:0]                crd_phi, crd_ang;
   logic                       crd_done;
   logic signed [Q15_W-1:0]    crd_cos, crd_sin;

   bo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .ctl     (crd_ctl),
      .x_in    (crd_x),
      .y_in    (crd_y),
      .phi_in  (crd_phi),
      .done    (crd_done),
      .ang_out (crd_ang),
      .cos_out (crd_cos),
      .sin_out (crd_sin)
   );

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= TS_IDLE;
         cutoff_ff <= CutoffReset;
         count_ff  <= '0;
         for (int j = 0; j < 3; j++) begin
            sre_ff[j] <= '0;
            sim_ff[j] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en)
            cutoff_ff <= csr_wr_data;
         count_ff <= count_in;
         sre_ff   <= sre_in;
         sim_ff   <= sim_in;
      end
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      self_ff  <= self_in;
      last_ff  <= last_in;
      r2_ff    <= r2_in;
      theta_ff <= theta_in;
      k_ff     <= k_in;
      acc_ff   <= acc_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      ord_ff   <= ord_in;
      ang_ff   <= ang_in;
   end

   // sequencer
   always_comb begin
      logic [CB-1:0]             ax, ay;
      logic signed [2*SUM_W-1:0] sq;
      logic [SQ_W-1:0]           trial;
      logic [CNT_W:0]            rsh;
      logic [31:0]               t;
      state_in = state_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      self_in  = self_ff;
      last_in  = last_ff;
      r2_in    = r2_ff;
      theta_in = theta_ff;
      k_in     = k_ff;
      sre_in   = sre_ff;
      sim_in   = sim_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      ord_in   = ord_ff;
      ang_in   = ang_ff;
      crd_ctl  = '0;
      crd_x    = CW'(dx_ff);
      crd_y    = CW'(dy_ff);
      ax       = CB'(dx_ff[CB-1] ? -dx_ff : dx_ff);
      ay       = CB'(dy_ff[CB-1] ? -dy_ff : dy_ff);
      sq       = '0;
      trial    = root_ff + bit_ff;
      rsh      = {rem_ff[CNT_W-1:0], num_ff[SUM_W-1]};
      t        = theta_ff;
      // multiple angle by shift and add/subtract
      unique case (k_ff)
         2'd0:    crd_phi = (t << 2) + t;
         2'd1:    crd_phi = (t << 2) + (t << 1);
         default: crd_phi = (t << 3) - t;
      endcase
      req_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;
      unique case (state_ff)
         TS_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               dx_in    = req_ch.dx;
               dy_in    = req_ch.dy;
               self_in  = req_ch.is_self;
               last_in  = req_ch.last_candidate;
               state_in = TS_SQX;
            end
         end
         TS_SQX: begin
            r2_in    = (2*CB+1)'(ax * ax);
            state_in = TS_SQY;
         end
         TS_SQY: begin
            r2_in    = r2_ff + (2*CB+1)'(ay * ay);
            state_in = TS_CHK;
         end
         TS_CHK: begin
            if (!self_ff && r2_ff < (2*CB+1)'(cutoff_ff)
                  && count_ff < CNT_W'(CountCap)) begin
               crd_ctl.start = 1'b1;
               state_in      = TS_VEC;
            end else begin
               state_in = TS_CLOSE;
            end
         end
         TS_VEC: begin
            if (crd_done) begin
               theta_in = crd_ang;
               k_in     = 2'd0;
               state_in = TS_RSTART;
            end
         end
         TS_RSTART: begin
            crd_ctl.start  = 1'b1;
            crd_ctl.rotate = 1'b1;
            state_in       = TS_ROT;
         end
         TS_ROT: begin
            if (crd_done) begin
               sre_in[k_ff] = sre_ff[k_ff] + SUM_W'(crd_cos);
               sim_in[k_ff] = sim_ff[k_ff] + SUM_W'(crd_sin);
               if (k_ff == 2'd2) begin
                  count_in = count_ff + CNT_W'(1);
                  state_in = TS_CLOSE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = TS_RSTART;
               end
            end
         end
         TS_CLOSE: begin
            crd_x = CW'(sre_ff[1]);
            crd_y = CW'(sim_ff[1]);
            if (!last_ff) begin
               state_in = TS_IDLE;
            end else if (count_ff == '0) begin
               for (int j = 0; j < 3; j++)
                  ord_in[j] = '0;
               ang_in   = '0;
               state_in = TS_OUT;
            end else begin
               crd_ctl.start = 1'b1;
               state_in      = TS_FVEC;
            end
         end
         TS_FVEC: begin
            if (crd_done) begin
               t        = crd_ang + 32'h8000;
               ang_in   = t[31:16];
               k_in     = 2'd0;
               state_in = TS_MSQR;
            end
         end
         TS_MSQR: begin
            sq       = sre_ff[k_ff] * sre_ff[k_ff];
            acc_in   = SQ_W'(sq);
            state_in = TS_MSQI;
         end
         TS_MSQI: begin
            sq       = sim_ff[k_ff] * sim_ff[k_ff];
            acc_in   = acc_ff + SQ_W'(sq);
            root_in  = '0;
            bit_in   = SQ_W'(64'd1) << (SQ_W - 2);
            step_in  = '0;
            state_in = TS_SQRT;
         end
         TS_SQRT: begin
            // one result bit a cycle
            if (acc_ff >= trial) begin
               acc_in  = acc_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(SQ_W / 2 - 1))
               state_in = TS_DIVI;
         end
         TS_DIVI: begin
            num_in   = SUM_W'(root_ff[MAG_W-1:0]) + SUM_W'(count_ff >> 1);
            rem_in   = '0;
            step_in  = '0;
            state_in = TS_DIV;
         end
         TS_DIV: begin
            // restoring divide, quotient shifts into num
            if (rsh >= {1'b0, count_ff}) begin
               rem_in = rsh - {1'b0, count_ff};
               num_in = {num_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = rsh;
               num_in = {num_ff[SUM_W-2:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(SUM_W - 1))
               state_in = TS_NEXT;
         end
         TS_NEXT: begin
            ord_in[k_ff] = (num_ff > SUM_W'(OrderMax)) ? OrderMax : num_ff[15:0];
            if (k_ff == 2'd2) begin
               state_in = TS_OUT;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = TS_MSQR;
            end
         end
         TS_OUT: begin
            rsp_ch.valid = 1'b1;
            if (rsp_ch.ready) begin
               for (int j = 0; j < 3; j++) begin
                  sre_in[j] = '0;
                  sim_in[j] = '0;
               end
               count_in = '0;
               state_in = TS_IDLE;
            end
         end
         default: state_in = TS_IDLE;
      endcase
   end

   // result word
   assign rsp_ch.order5          = ord_ff[0];
   assign rsp_ch.order6          = ord_ff[1];
   assign rsp_ch.order7          = ord_ff[2];
   assign rsp_ch.order6_angle    = $signed(ang_ff);
   assign rsp_ch.neighbour_count = count_ff;

endmodule
